// ===== sv/lcno_pkg.sv =====
package lcno_pkg;

    // Default sizes of the datapath.
    localparam int RANGE_BITS_DEF       = 16;
    localparam int ANGLE_BITS_DEF       = 16;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;

    // Fixed field widths.
    localparam int REG_W      = 16;
    localparam int COORD_W    = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int OUT_DATA_W = ((2 * COORD_W + 7) / 8) * 8;

    // Sine table entries are Q1.15 with room for +1.0.
    localparam int SINE_W = 17;
    localparam int MAG_W  = 16;

    // Angles in Q30 radians for building the sine table.
    localparam longint PI_Q30      = 64'd3373259426;
    localparam longint TWO_PI_Q30  = 64'd6746518852;
    localparam longint HALF_PI_Q30 = 64'd1686629713;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CORRIDOR_NEAR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CORRIDOR_FAR  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH    = 3'd6;

    // Register reset values.
    localparam logic [REG_W-1:0]          START_ANGLE_RST   = 16'd0;
    localparam logic [REG_W-1:0]          ANGLE_STEP_RST    = 16'd0;
    localparam logic [REG_W-1:0]          RANGE_LOW_RST     = 16'd0;
    localparam logic [REG_W-1:0]          RANGE_HIGH_RST    = 16'd65535;
    localparam logic signed [COORD_W-1:0] CORRIDOR_NEAR_RST = 17'sd400;
    localparam logic signed [COORD_W-1:0] CORRIDOR_FAR_RST  = 17'sd2000;
    localparam logic [REG_W-1:0]          HALF_WIDTH_RST    = 16'd1200;

    // Reset value of the best forward distance.
    localparam logic signed [COORD_W-1:0] BEST_RESET = 17'sd65535;

    // Configuration registers as one bundle.
    typedef struct packed {
        logic [REG_W-1:0]          start_angle;
        logic [REG_W-1:0]          angle_step;
        logic [REG_W-1:0]          range_low;
        logic [REG_W-1:0]          range_high;
        logic signed [COORD_W-1:0] corridor_near;
        logic signed [COORD_W-1:0] corridor_far;
        logic [REG_W-1:0]          lateral_limit;
    } cfg_t;

    // Control that travels with a sample down the pipeline.
    typedef struct packed {
        logic valid;
        logic last;
        logic keep;
    } item_ctl_t;

endpackage

// ===== sv/lcno_polar.sv =====
module lcno_polar #(
    parameter int RANGE_BITS       = lcno_pkg::RANGE_BITS_DEF,
    parameter int ANGLE_BITS       = lcno_pkg::ANGLE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = lcno_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_take,
    input  logic [RANGE_BITS-1:0]               range_mm,
    input  logic                                range_valid,
    input  logic                                scan_last,
    input  lcno_pkg::cfg_t                      cfg,
    input  logic                                angle_load,
    input  logic [lcno_pkg::REG_W-1:0]          angle_load_value,
    output lcno_pkg::item_ctl_t                 s1_ctl,
    output logic [RANGE_BITS-1:0]               s1_range,
    output logic signed [lcno_pkg::SINE_W-1:0]  s1_sin,
    output logic signed [lcno_pkg::SINE_W-1:0]  s1_cos
);

    localparam int IDX_W    = $clog2(SINE_TABLE_DEPTH);
    localparam int PROD_W   = ANGLE_BITS + IDX_W + 1;
    localparam int LIM_W    = (RANGE_BITS > lcno_pkg::REG_W) ? RANGE_BITS : lcno_pkg::REG_W;
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    typedef logic signed [lcno_pkg::SINE_W-1:0] rom_t [SINE_TABLE_DEPTH];

    // One sine entry: Taylor series in Q30 on the angle folded into the
    // first quadrant, rounded half up to Q15.
    function automatic logic signed [lcno_pkg::SINE_W-1:0] sine_entry(input longint k);
        longint          theta;
        logic            neg;
        longint unsigned th2;
        longint unsigned term;
        longint unsigned prod;
        longint          sum;
        longint          n;
        theta = (lcno_pkg::TWO_PI_Q30 * k) / SINE_TABLE_DEPTH;
        neg   = 1'b0;
        if (theta > lcno_pkg::PI_Q30)
        begin
            theta = lcno_pkg::TWO_PI_Q30 - theta;
            neg   = 1'b1;
        end
        if (theta > lcno_pkg::HALF_PI_Q30)
        begin
            theta = lcno_pkg::PI_Q30 - theta;
        end
        th2  = (longint'(theta) * longint'(theta)) >> 30;
        term = longint'(theta);
        sum  = theta;
        for (n = 1; n < 16; n++)
        begin
            if (term != 0)
            begin
                prod = (term * th2) >> 30;
                // The n-th term is divided by (2n)(2n+1).
                case (n)
                    1:       term = prod / 64'd6;
                    2:       term = prod / 64'd20;
                    3:       term = prod / 64'd42;
                    4:       term = prod / 64'd72;
                    5:       term = prod / 64'd110;
                    6:       term = prod / 64'd156;
                    7:       term = prod / 64'd210;
                    8:       term = prod / 64'd272;
                    9:       term = prod / 64'd342;
                    10:      term = prod / 64'd420;
                    11:      term = prod / 64'd506;
                    12:      term = prod / 64'd600;
                    13:      term = prod / 64'd702;
                    14:      term = prod / 64'd812;
                    15:      term = prod / 64'd930;
                    default: term = 64'd0;
                endcase
                if (n[0])
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        sum = (sum + 64'sd16384) >>> 15;
        return neg ? lcno_pkg::SINE_W'(-sum) : lcno_pkg::SINE_W'(sum);
    endfunction

    function automatic rom_t build_rom();
        rom_t t;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            t[k] = sine_entry(longint'(k));
        end
        return t;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [ANGLE_BITS-1:0] sample_angle_reg;
    logic [ANGLE_BITS-1:0] sample_angle_next;
    logic [ANGLE_BITS-1:0] start_masked;
    logic [ANGLE_BITS-1:0] cos_angle;
    logic [PROD_W-1:0]     sin_prod;
    logic [PROD_W-1:0]     cos_prod;
    logic [IDX_W-1:0]      sin_idx;
    logic [IDX_W-1:0]      cos_idx;
    logic                  in_limits;
    lcno_pkg::item_ctl_t   ctl_reg;
    lcno_pkg::item_ctl_t   ctl_next;
    logic signed [lcno_pkg::SINE_W-1:0] sin_reg;
    logic signed [lcno_pkg::SINE_W-1:0] cos_reg;
    logic [RANGE_BITS-1:0]              range_reg;

    assign start_masked = ANGLE_BITS'(cfg.start_angle);

    // Beam angle advances after every sample and restarts after the last one.
    always_comb
    begin
        sample_angle_next = sample_angle_reg;
        if (angle_load)
        begin
            sample_angle_next = ANGLE_BITS'(angle_load_value);
        end
        else if (in_take)
        begin
            if (scan_last)
            begin
                sample_angle_next = start_masked;
            end
            else
            begin
                sample_angle_next = sample_angle_reg + ANGLE_BITS'(cfg.angle_step);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_angle_reg <= ANGLE_BITS'(lcno_pkg::START_ANGLE_RST);
        end
        else
        begin
            sample_angle_reg <= sample_angle_next;
        end
    end

    // Table indexes for sine and for cosine (a quarter turn ahead).
    assign cos_angle = sample_angle_reg + QUARTER;
    assign sin_prod  = PROD_W'(sample_angle_reg) * PROD_W'(SINE_TABLE_DEPTH);
    assign cos_prod  = PROD_W'(cos_angle) * PROD_W'(SINE_TABLE_DEPTH);
    assign sin_idx   = IDX_W'(sin_prod >> ANGLE_BITS);
    assign cos_idx   = IDX_W'(cos_prod >> ANGLE_BITS);

    // Range gate.
    assign in_limits = (LIM_W'(range_mm) >= LIM_W'(cfg.range_low)) &&
                       (LIM_W'(range_mm) <= LIM_W'(cfg.range_high));

    always_comb
    begin
        ctl_next.valid = in_take;
        ctl_next.last  = scan_last;
        ctl_next.keep  = range_valid && in_limits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    // Table read with registered data.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg   <= SINE_ROM[sin_idx];
            cos_reg   <= SINE_ROM[cos_idx];
            range_reg <= range_mm;
        end
    end

    assign s1_ctl   = ctl_reg;
    assign s1_sin   = sin_reg;
    assign s1_cos   = cos_reg;
    assign s1_range = range_reg;

endmodule

// ===== sv/lcno_scale.sv =====
module lcno_scale #(
    parameter int RANGE_BITS = lcno_pkg::RANGE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  lcno_pkg::item_ctl_t                s1_ctl,
    input  logic [RANGE_BITS-1:0]              s1_range,
    input  logic signed [lcno_pkg::SINE_W-1:0] s1_sin,
    input  logic signed [lcno_pkg::SINE_W-1:0] s1_cos,
    output lcno_pkg::item_ctl_t                s2_ctl,
    output logic signed [RANGE_BITS:0]         s2_x,
    output logic signed [RANGE_BITS:0]         s2_y
);

    localparam int PROD_W = RANGE_BITS + lcno_pkg::MAG_W;

    logic [lcno_pkg::SINE_W-1:0] sin_abs;
    logic [lcno_pkg::SINE_W-1:0] cos_abs;
    logic [PROD_W-1:0]           x_prod;
    logic [PROD_W-1:0]           y_prod;
    logic [RANGE_BITS-1:0]       x_mag;
    logic [RANGE_BITS-1:0]       y_mag;
    logic signed [RANGE_BITS:0]  x_next;
    logic signed [RANGE_BITS:0]  y_next;
    logic signed [RANGE_BITS:0]  x_reg;
    logic signed [RANGE_BITS:0]  y_reg;
    lcno_pkg::item_ctl_t         ctl_reg;

    // Range times table magnitude, rounded half away from zero.
    assign sin_abs = s1_sin[lcno_pkg::SINE_W-1] ? -s1_sin : s1_sin;
    assign cos_abs = s1_cos[lcno_pkg::SINE_W-1] ? -s1_cos : s1_cos;
    assign x_prod  = PROD_W'(s1_range) * PROD_W'(cos_abs[lcno_pkg::MAG_W-1:0]);
    assign y_prod  = PROD_W'(s1_range) * PROD_W'(sin_abs[lcno_pkg::MAG_W-1:0]);
    assign x_mag   = RANGE_BITS'((x_prod + PROD_W'(16384)) >> 15);
    assign y_mag   = RANGE_BITS'((y_prod + PROD_W'(16384)) >> 15);

    always_comb
    begin
        x_next = $signed({1'b0, x_mag});
        y_next = $signed({1'b0, y_mag});
        if (s1_cos[lcno_pkg::SINE_W-1])
        begin
            x_next = -x_next;
        end
        if (s1_sin[lcno_pkg::SINE_W-1])
        begin
            y_next = -y_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= s1_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign s2_ctl = ctl_reg;
    assign s2_x   = x_reg;
    assign s2_y   = y_reg;

endmodule

// ===== sv/lcno_track.sv =====
module lcno_track #(
    parameter int RANGE_BITS = lcno_pkg::RANGE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  lcno_pkg::item_ctl_t                 s2_ctl,
    input  logic signed [RANGE_BITS:0]          s2_x,
    input  logic signed [RANGE_BITS:0]          s2_y,
    input  lcno_pkg::cfg_t                      cfg,
    input  logic                                out_ready,
    output logic                                stall,
    output logic                                out_valid,
    output logic                                out_detected,
    output logic signed [lcno_pkg::COORD_W-1:0] out_x,
    output logic signed [lcno_pkg::COORD_W-1:0] out_y
);

    localparam int CMP_W = (RANGE_BITS + 1 > lcno_pkg::COORD_W + 1) ?
                           RANGE_BITS + 1 : lcno_pkg::COORD_W + 1;

    logic signed [lcno_pkg::COORD_W-1:0] best_forward_reg;
    logic signed [lcno_pkg::COORD_W-1:0] best_forward_next;
    logic signed [lcno_pkg::COORD_W-1:0] best_lateral_reg;
    logic signed [lcno_pkg::COORD_W-1:0] best_lateral_next;
    logic                                found_reg;
    logic                                found_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic                                out_detected_reg;
    logic signed [lcno_pkg::COORD_W-1:0] out_x_reg;
    logic signed [lcno_pkg::COORD_W-1:0] out_y_reg;

    logic signed [CMP_W-1:0] x_ext;
    logic signed [CMP_W-1:0] y_ext;
    logic signed [CMP_W-1:0] y_abs;
    logic                    in_corridor;
    logic                    closer;
    logic                    take;
    logic                    emit;
    logic                    upd_found;
    logic signed [lcno_pkg::COORD_W-1:0] upd_forward;
    logic signed [lcno_pkg::COORD_W-1:0] upd_lateral;

    // A stuck result holds the whole pipeline at the next scan's end.
    assign stall = s2_ctl.valid && s2_ctl.last && out_valid_reg && !out_ready;
    assign take  = en && s2_ctl.valid;
    assign emit  = take && s2_ctl.last;

    // Corridor test and strict nearest comparison.
    assign x_ext = CMP_W'(s2_x);
    assign y_ext = CMP_W'(s2_y);
    assign y_abs = y_ext[CMP_W-1] ? -y_ext : y_ext;

    assign in_corridor = s2_ctl.keep &&
                         (x_ext >= CMP_W'(cfg.corridor_near)) &&
                         (x_ext <= CMP_W'(cfg.corridor_far)) &&
                         (y_abs <= $signed(CMP_W'(cfg.lateral_limit)));
    assign closer = !found_reg || (x_ext < CMP_W'(best_forward_reg));

    always_comb
    begin
        upd_found   = found_reg;
        upd_forward = best_forward_reg;
        upd_lateral = best_lateral_reg;
        if (in_corridor && closer)
        begin
            upd_found   = 1'b1;
            upd_forward = lcno_pkg::COORD_W'(s2_x);
            upd_lateral = lcno_pkg::COORD_W'(s2_y);
        end
    end

    // Running state clears after the last sample of a scan.
    always_comb
    begin
        found_next        = found_reg;
        best_forward_next = best_forward_reg;
        best_lateral_next = best_lateral_reg;
        if (take)
        begin
            if (s2_ctl.last)
            begin
                found_next        = 1'b0;
                best_forward_next = lcno_pkg::BEST_RESET;
                best_lateral_next = '0;
            end
            else
            begin
                found_next        = upd_found;
                best_forward_next = upd_forward;
                best_lateral_next = upd_lateral;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg        <= 1'b0;
            best_forward_reg <= lcno_pkg::BEST_RESET;
            best_lateral_reg <= '0;
        end
        else
        begin
            found_reg        <= found_next;
            best_forward_reg <= best_forward_next;
            best_lateral_reg <= best_lateral_next;
        end
    end

    // Output register: loaded at the end of a scan, freed by a transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_detected_reg <= upd_found;
            out_x_reg        <= upd_found ? upd_forward : '0;
            out_y_reg        <= upd_found ? upd_lateral : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_detected = out_detected_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;

endmodule

// ===== sv/lidar_corridor_nearest_obstacle.sv =====
// Result path: a result is offered on m_tvalid once the last sample of a scan
// has passed the table read registered at its transfer, then the scaling
// multiply, then the corridor compare into the output register.
// Throughput: one sample per cycle; the input stalls only while a scan result
// waits in the output register and the next scan result has reached it.
// Reset: rst_n clears the registers to their defaults, the beam angle to the
// start angle and the nearest-point search to empty; no clearing pass.
module lidar_corridor_nearest_obstacle #(
    parameter int RANGE_BITS       = lcno_pkg::RANGE_BITS_DEF,
    parameter int ANGLE_BITS       = lcno_pkg::ANGLE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = lcno_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((RANGE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // range_mm
    input  logic                                s_tuser,  // range_valid
    input  logic                                s_tlast,  // scan_last
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lcno_pkg::OUT_DATA_W-1:0]     m_tdata,  // nearest_x, nearest_y
    output logic                                m_tuser,  // detected
    // Configuration writes
    input  logic                                cfg_we,
    input  logic [lcno_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lcno_pkg::CFG_DATA_W-1:0]     cfg_data
);

    lcno_pkg::cfg_t            cfg_reg;
    lcno_pkg::cfg_t            cfg_next;
    logic                      angle_load;
    logic                      en;
    logic                      stall;
    logic                      in_take;
    lcno_pkg::item_ctl_t       s1_ctl;
    logic [RANGE_BITS-1:0]     s1_range;
    logic signed [lcno_pkg::SINE_W-1:0] s1_sin;
    logic signed [lcno_pkg::SINE_W-1:0] s1_cos;
    lcno_pkg::item_ctl_t       s2_ctl;
    logic signed [RANGE_BITS:0] s2_x;
    logic signed [RANGE_BITS:0] s2_y;
    logic                      out_detected;
    logic signed [lcno_pkg::COORD_W-1:0] out_x;
    logic signed [lcno_pkg::COORD_W-1:0] out_y;

    // Register write decode.
    always_comb
    begin
        cfg_next   = cfg_reg;
        angle_load = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                lcno_pkg::REG_START_ANGLE:
                begin
                    cfg_next.start_angle = cfg_data[lcno_pkg::REG_W-1:0];
                    angle_load           = 1'b1;
                end
                lcno_pkg::REG_ANGLE_STEP:
                    cfg_next.angle_step = cfg_data[lcno_pkg::REG_W-1:0];
                lcno_pkg::REG_RANGE_LOW:
                    cfg_next.range_low = cfg_data[lcno_pkg::REG_W-1:0];
                lcno_pkg::REG_RANGE_HIGH:
                    cfg_next.range_high = cfg_data[lcno_pkg::REG_W-1:0];
                lcno_pkg::REG_CORRIDOR_NEAR:
                    cfg_next.corridor_near = $signed(cfg_data);
                lcno_pkg::REG_CORRIDOR_FAR:
                    cfg_next.corridor_far = $signed(cfg_data);
                lcno_pkg::REG_HALF_WIDTH:
                    cfg_next.lateral_limit = cfg_data[lcno_pkg::REG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_angle   <= lcno_pkg::START_ANGLE_RST;
            cfg_reg.angle_step    <= lcno_pkg::ANGLE_STEP_RST;
            cfg_reg.range_low     <= lcno_pkg::RANGE_LOW_RST;
            cfg_reg.range_high    <= lcno_pkg::RANGE_HIGH_RST;
            cfg_reg.corridor_near <= lcno_pkg::CORRIDOR_NEAR_RST;
            cfg_reg.corridor_far  <= lcno_pkg::CORRIDOR_FAR_RST;
            cfg_reg.lateral_limit <= lcno_pkg::HALF_WIDTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Pipeline advance and input transfer.
    assign en       = !stall;
    assign s_tready = en;
    assign in_take  = s_tvalid && en;

    lcno_polar #(
        .RANGE_BITS       (RANGE_BITS),
        .ANGLE_BITS       (ANGLE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_polar (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_take          (in_take),
        .range_mm         (s_tdata[RANGE_BITS-1:0]),
        .range_valid      (s_tuser),
        .scan_last        (s_tlast),
        .cfg              (cfg_reg),
        .angle_load       (angle_load),
        .angle_load_value (cfg_data[lcno_pkg::REG_W-1:0]),
        .s1_ctl           (s1_ctl),
        .s1_range         (s1_range),
        .s1_sin           (s1_sin),
        .s1_cos           (s1_cos)
    );

    lcno_scale #(
        .RANGE_BITS (RANGE_BITS)
    ) u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .s1_ctl     (s1_ctl),
        .s1_range   (s1_range),
        .s1_sin     (s1_sin),
        .s1_cos     (s1_cos),
        .s2_ctl     (s2_ctl),
        .s2_x       (s2_x),
        .s2_y       (s2_y)
    );

    lcno_track #(
        .RANGE_BITS   (RANGE_BITS)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .s2_ctl       (s2_ctl),
        .s2_x         (s2_x),
        .s2_y         (s2_y),
        .cfg          (cfg_reg),
        .out_ready    (m_tready),
        .stall        (stall),
        .out_valid    (m_tvalid),
        .out_detected (out_detected),
        .out_x        (out_x),
        .out_y        (out_y)
    );

    // Result packing: nearest_x in the low bits, then nearest_y, zero filled.
    assign m_tdata = {{(lcno_pkg::OUT_DATA_W - 2 * lcno_pkg::COORD_W){1'b0}}, out_y, out_x};
    assign m_tuser = out_detected;

endmodule
